FILE: hdl/sha1mh_pkg.sv
package sha1mh_pkg;

  typedef logic [0:4][31:0] hash_t;

  localparam hash_t HASH_IV = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [0:3][31:0] ROUND_K = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [7:0] PAD_MARK      = 8'h80;
  localparam logic [7:0] PAD_ZERO      = 8'h00;
  localparam logic [5:0] BLOCK_LAST    = 6'd63;
  localparam logic [5:0] LEN_POS       = 6'd56;
  localparam logic [3:0] LEN_BYTES     = 4'd8;
  localparam logic [6:0] ROUND_LAST    = 7'd79;
  localparam logic [2:0] WORD_LAST     = 3'd4;

  typedef enum logic [1:0] {
    PH_CH,
    PH_PAR0,
    PH_MAJ,
    PH_PAR1
  } phase_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_FINAL
  } core_state_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_PAD,
    SEQ_COMP,
    SEQ_OUT
  } seq_state_t;

  typedef struct packed {
    logic word_valid;
    logic start;
    logic init;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  function automatic logic [31:0] round_f(phase_t ph, logic [31:0] b, logic [31:0] c,
                                          logic [31:0] d);
    logic [31:0] f;
    unique case (ph)
      PH_CH:   f = (b & c) | (~b & d);
      PH_MAJ:  f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

FILE: hdl/sha1mh_core.sv
module sha1mh_core
  import sha1mh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  core_ctl_t   ctl,
  input  logic [31:0] word,
  output core_stat_t  stat,
  output hash_t       hash
);

  core_state_t       state, state_next;
  logic [6:0]        rnd;
  logic [0:15][31:0] win;
  logic [31:0]       a, b, c, d, e;
  logic [31:0]       w, x, t;
  phase_t            ph;

  // schedule: window shifts down one word per round, oldest at index 0
  always_comb begin
    x = win[13] ^ win[8] ^ win[2] ^ win[0];
    w = (rnd < 7'd16) ? win[0] : {x[30:0], x[31]};
    if (rnd < 7'd20) begin
      ph = PH_CH;
    end else if (rnd < 7'd40) begin
      ph = PH_PAR0;
    end else if (rnd < 7'd60) begin
      ph = PH_MAJ;
    end else begin
      ph = PH_PAR1;
    end
    t = {a[26:0], a[31:27]} + round_f(ph, b, c, d) + e + ROUND_K[ph] + w;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CORE_IDLE:  if (ctl.start) state_next = CORE_ROUND;
      CORE_ROUND: if (rnd == ROUND_LAST) state_next = CORE_FINAL;
      CORE_FINAL: state_next = CORE_IDLE;
      default:    state_next = CORE_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = (state != CORE_IDLE);
    stat.done = (state == CORE_FINAL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
      rnd   <= '0;
      hash  <= HASH_IV;
    end else begin
      state <= state_next;
      if (ctl.start) begin
        rnd <= '0;
      end else if (state == CORE_ROUND) begin
        rnd <= rnd + 7'd1;
      end
      if (ctl.init) begin
        hash <= HASH_IV;
      end else if (state == CORE_FINAL) begin
        hash[0] <= hash[0] + a;
        hash[1] <= hash[1] + b;
        hash[2] <= hash[2] + c;
        hash[3] <= hash[3] + d;
        hash[4] <= hash[4] + e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.word_valid) begin
      win <= {win[1:15], word};
    end else if (state == CORE_ROUND) begin
      win <= {win[1:15], w};
    end
    if (ctl.start) begin
      a <= hash[0];
      b <= hash[1];
      c <= hash[2];
      d <= hash[3];
      e <= hash[4];
    end else if (state == CORE_ROUND) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

endmodule

FILE: hdl/sha1_message_hash.sv
// Message bytes are taken while idle; a byte that completes a 64-byte block
// holds off requests through the 80 rounds (one per cycle) and the chaining add.
// End of message: the pad bytes, one or two more block passes, then
// five digest words, one per cycle while not stalled.
// Reset (rst, synchronous): chaining hash to the initial values, count zero, idle.
module sha1_message_hash
  import sha1mh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic        digest_last
);

  seq_state_t  state, state_next;
  core_ctl_t   ctl;
  core_stat_t  stat;
  hash_t       hash;

  logic [60:0] byte_cnt;
  logic [60:0] cnt_after;
  logic [5:0]  pos;
  logic [23:0] acc;
  logic        pad_active;
  logic        sent80;
  logic [3:0]  len_cnt;
  logic [63:0] len_sh;
  logic [2:0]  out_idx;

  logic        accept;
  logic        out_take;
  logic        push_en;
  logic [7:0]  push_byte;
  logic [7:0]  pad_byte;
  logic        len_phase;

  sha1mh_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .word ({acc, push_byte}),
    .stat (stat),
    .hash (hash)
  );

  assign pos       = byte_cnt[5:0];
  assign cnt_after = byte_cnt + {60'd0, has_byte};
  assign len_phase = sent80 && ((len_cnt != 4'd0) || (pos == LEN_POS));

  always_comb begin
    if (!sent80) begin
      pad_byte = PAD_MARK;
    end else if (len_phase) begin
      pad_byte = len_sh[63:56];
    end else begin
      pad_byte = PAD_ZERO;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (accept) begin
          if (has_byte && (pos == BLOCK_LAST)) begin
            state_next = SEQ_COMP;
          end else if (end_of_message) begin
            state_next = SEQ_PAD;
          end
        end
      end
      SEQ_PAD: if (pos == BLOCK_LAST) state_next = SEQ_COMP;
      SEQ_COMP: begin
        if (stat.done) begin
          if (!pad_active) begin
            state_next = SEQ_IDLE;
          end else if (len_cnt == LEN_BYTES) begin
            state_next = SEQ_OUT;
          end else begin
            state_next = SEQ_PAD;
          end
        end
      end
      SEQ_OUT: if (out_take && digest_last) state_next = SEQ_IDLE;
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state != SEQ_IDLE);
    accept         = in_valid && !in_stall;
    out_valid      = (state == SEQ_OUT);
    out_take       = out_valid && !out_stall;
    digest_last    = (out_idx == WORD_LAST);
    digest_word    = hash[out_idx];
    push_en        = (accept && has_byte) || (state == SEQ_PAD);
    push_byte      = (state == SEQ_PAD) ? pad_byte : data_byte;
    ctl.word_valid = push_en && (pos[1:0] == 2'b11);
    ctl.start      = push_en && (pos == BLOCK_LAST);
    ctl.init       = out_take && digest_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SEQ_IDLE;
      byte_cnt   <= '0;
      pad_active <= 1'b0;
      sent80     <= 1'b0;
      len_cnt    <= '0;
      out_idx    <= '0;
    end else begin
      state <= state_next;
      if (ctl.init) begin
        byte_cnt   <= '0;
        pad_active <= 1'b0;
        sent80     <= 1'b0;
        len_cnt    <= '0;
        out_idx    <= '0;
      end else begin
        if (push_en) begin
          byte_cnt <= byte_cnt + 61'd1;
        end
        if (accept && end_of_message) begin
          pad_active <= 1'b1;
        end
        if (state == SEQ_PAD) begin
          if (!sent80) begin
            sent80 <= 1'b1;
          end else if (len_phase) begin
            len_cnt <= len_cnt + 4'd1;
          end
        end
        if (out_take) begin
          out_idx <= out_idx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      acc <= {acc[15:0], push_byte};
    end
    if (accept && end_of_message) begin
      len_sh <= {cnt_after, 3'b000};
    end else if ((state == SEQ_PAD) && len_phase) begin
      len_sh <= {len_sh[55:0], 8'h00};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !stat.busy)
    else $error("block pass started while core busy");

  a_word_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.word_valid |-> !stat.busy)
    else $error("schedule word pushed during rounds");

  a_out_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pos == 6'd0) && (len_cnt == LEN_BYTES))
    else $error("digest out before padding complete");

  a_reinit: assert property (@(posedge clk) disable iff (rst)
    (out_take && digest_last) |=> !in_stall && (byte_cnt == 61'd0) && !pad_active)
    else $error("no reinit after final digest word");

endmodule

FILE: tb/sha1_message_hash_tb.sv
module sha1_message_hash_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int END_WAIT       = 300;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_PER_PH  = 4;

  localparam logic [31:0] K_CH   = 32'h5A827999;
  localparam logic [31:0] K_PAR0 = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
  localparam logic [31:0] K_PAR1 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [5:0]  LEN_AT     = 6'd56;
  localparam logic [5:0]  BLOCK_END  = 6'd63;

  localparam sha1mh_pkg::hash_t SHA1_IV = {
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef struct {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } hash_req_t;

  typedef struct {
    logic [31:0] word;
    logic        last;
  } digest_exp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        has_byte = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic        digest_last;

  hash_req_t   req_q[$];
  digest_exp_t digest_q[$];
  hash_req_t   nxt_req;
  digest_exp_t got_exp;

  sha1mh_pkg::hash_t chain_h;
  logic [7:0]        blk_bytes [64];
  logic [63:0]       msg_bits;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_taken     = 0;
  int hold_left      = 0;
  int idle_run       = 0;
  int fails          = 0;
  int n_queued       = 0;
  int n_req          = 0;
  int n_msgs         = 0;
  int n_words        = 0;
  int target;

  sha1_message_hash DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .has_byte(has_byte),
    .end_of_message(end_of_message),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .digest_word(digest_word),
    .digest_last(digest_last)
  );

  always #2 clk = ~clk;

  task automatic hash_restart();
    chain_h  = SHA1_IV;
    msg_bits = '0;
  endtask

  task automatic sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        t = w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16];
        w[r%16] = {t[30:0], t[31]};
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_PAR0;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_PAR1;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r%16];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] = chain_h[0] + a;
    chain_h[1] = chain_h[1] + b;
    chain_h[2] = chain_h[2] + c;
    chain_h[3] = chain_h[3] + d;
    chain_h[4] = chain_h[4] + e;
  endtask

  task automatic sha1_absorb(logic [7:0] v);
    logic [5:0] pos;
    pos = msg_bits[8:3];
    blk_bytes[pos] = v;
    msg_bits = msg_bits + 64'd8;
    if (pos == BLOCK_END) sha1_compress();
  endtask

  task automatic predict_request(logic [7:0] d, logic hb, logic eom);
    logic [63:0] len_bits;
    digest_exp_t de;
    if (hb) sha1_absorb(d);
    if (eom) begin
      len_bits = msg_bits;
      sha1_absorb(PAD_BYTE);
      while (msg_bits[8:3] != LEN_AT) sha1_absorb(8'h00);
      for (int i = 0; i < 8; i++) sha1_absorb(len_bits[63 - 8*i -: 8]);
      for (int i = 0; i < 5; i++) begin
        de.word = chain_h[i];
        de.last = (i == 4);
        digest_q.push_back(de);
      end
      hash_restart();
    end
  endtask

  task automatic note_fail(string msg);
    fails++;
    if (fails <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic add_req(logic [7:0] d, logic hb, logic eom);
    hash_req_t r;
    r.data     = d;
    r.has_byte = hb;
    r.eom      = eom;
    req_q.push_back(r);
    if (hb || eom) n_queued++;
  endtask

  // random bytes, a few idle items mixed in, end marker on the last byte or alone
  task automatic add_message(int len, bit eom_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(7) == 0) add_req(8'($urandom_range(255)), 1'b0, 1'b0);
      add_req(8'($urandom_range(255)), 1'b1, eom_on_byte && (i == len - 1));
    end
    if (!eom_on_byte || len == 0) add_req(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_request(data_byte, has_byte, end_of_message);
        n_req++;
        if (end_of_message) n_msgs++;
      end
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt_req = req_q.pop_front();
          data_byte      <= nxt_req.data;
          has_byte       <= nxt_req.has_byte;
          end_of_message <= nxt_req.eom;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // digest monitor and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_words++;
        if (digest_q.size() == 0) begin
          note_fail($sformatf("unexpected word %h last %b", digest_word, digest_last));
        end else begin
          got_exp = digest_q.pop_front();
          if (digest_word !== got_exp.word || digest_last !== got_exp.last)
            note_fail($sformatf("expected word %h last %b, got word %h last %b",
                                got_exp.word, got_exp.last, digest_word, digest_last));
        end
      end
      if (hold_taken != hold_asked) begin
        hold_taken <= hold_asked;
        hold_left  <= HOLD_CYCLES;
        out_stall  <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_run <= 0;
      end else if (idle_run + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("sha1_message_hash test failed");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  initial begin
    hash_restart();
    for (int i = 0; i < 64; i++) blk_bytes[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 5; ph++) begin
      @(negedge clk);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        3: begin send_idle_pct = 31; recv_stall_pct = 31; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 0) begin
        add_req(8'hA5, 1'b0, 1'b0);
        add_req(8'hFF, 1'b0, 1'b1);
        add_req(8'h00, 1'b0, 1'b1);
        add_req(8'h61, 1'b1, 1'b0);
        add_req(8'h62, 1'b1, 1'b0);
        add_req(8'h63, 1'b1, 1'b1);
        add_req(8'h00, 1'b1, 1'b0);
        add_req(8'hFF, 1'b1, 1'b0);
        add_req(8'h5A, 1'b0, 1'b0);
        add_req(8'h00, 1'b0, 1'b1);
        add_req(8'h80, 1'b1, 1'b1);
        // length spills into a second pad block, then an exact block end
        add_message(57, 1'b1);
        add_message(64, 1'b0);
      end
      if (ph == 4) begin
        hold_asked++;
        for (int m = 0; m < 3; m++) add_message($urandom_range(2, 4), 1'($urandom_range(1)));
      end
      target = n_queued + ((ph == 4) ? RANDOM_PER_PH / 2 : RANDOM_PER_PH);
      while (n_queued < target) begin
        add_message($urandom_range(0, 9), 1'($urandom_range(1)));
      end
      do @(negedge clk);
      while (req_q.size() != 0 || in_valid || digest_q.size() != 0);
    end
    repeat (END_WAIT) @(posedge clk);
    if (digest_q.size() != 0) note_fail($sformatf("%0d digest words never came",
                                                  digest_q.size()));
    $display("Run covered %0d requests, %0d messages and %0d digest words", n_req, n_msgs,
             n_words);
    $display("over free flow, sparse sender, slow receiver, mixed gaps and a long hold.");
    if (fails == 0) begin
      $display("sha1_message_hash test passed");
    end else begin
      $display("%0d mismatches", fails);
      $display("sha1_message_hash test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/sha1mh_pkg.sv
hdl/sha1mh_core.sv
hdl/sha1_message_hash.sv
tb/sha1_message_hash_tb.sv
